// ----- hdl/tpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants of the tree path distance engine
// Field widths, status codes, job word and the control structs between
// the front and back ends.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int unsigned NODE_W   = 10;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned DIST_W   = 48;
  localparam int unsigned STATUS_W = 2;
  // wide enough to hold the largest node count
  localparam int unsigned RANGE_W  = 17;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SELF  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_APART = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_QUERY,
    KIND_REJECT
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEP_A,
    S_DEP_B,
    S_LIFT,
    S_PAIR_A,
    S_PAIR_B
  } bk_state_e;

  typedef struct packed {
    kind_e                 kind;
    logic [STATUS_W-1:0]   status;
    logic [NODE_W-1:0]     node_a;
    logic [NODE_W-1:0]     node_b;
    logic [WEIGHT_W-1:0]   weight;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fr_st_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctl_t;

  function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] acc,
                                                input logic [WEIGHT_W-1:0] w);
    logic [DIST_W:0] s;
    s = {1'b0, acc} + (DIST_W+1)'(w);
    return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
  endfunction

endpackage

// ----- hdl/tree_path_distance_engine.sv -----
// ----------------------------------------------------------------------------
// tree_path_distance_engine: weighted tree path length
// Keeps parent links and edge weights of a rooted forest and answers
// path length queries between two nodes.
// ----------------------------------------------------------------------------
// After reset the link memory is cleared with busy high.
// A word is taken when start is high and busy low; busy rises only when
// the two-word queue is full or during the clearing pass. Each word gives
// exactly one result on result_valid_o for one cycle, in order; results
// cannot be held off. Inserts and rejected words are answered from the
// idle state. A query walks up from both nodes to find their depths da and
// db, lifts the deeper one by |da - db| levels, then steps both up in turn
// until they meet: the walker follows one parent link per cycle through the
// single read port of the link memory.
module tree_path_distance_engine
  import tpd_pkg::*;
#(
  parameter int unsigned NODES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                command_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  output logic                result_valid_o,
  output logic [DIST_W-1:0]   distance_o,
  output logic [STATUS_W-1:0] status_o
);

  job_t    job;
  fr_st_t  fr_st;
  bk_ctl_t bk_ctl;

  tpd_front #(
    .NODES (NODES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .command_i     (command_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .edge_weight_i (edge_weight_i),
    .bk_ctl_i      (bk_ctl),
    .job_o         (job),
    .fr_st_o       (fr_st)
  );

  tpd_back #(
    .NODES (NODES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job),
    .fr_st_i        (fr_st),
    .bk_ctl_o       (bk_ctl),
    .result_valid_o (result_valid_o),
    .distance_o     (distance_o),
    .status_o       (status_o)
  );

`ifndef SYNTH
  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_ctl.pop |-> fr_st.valid)
    else $error("queue popped while empty");

  a_fail_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != STATUS_OK |-> distance_o == '0)
    else $error("failed word carries a distance");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_ctl.clearing |=> !result_valid_o)
    else $error("result during clearing pass");
`endif

endmodule

// ----- hdl/tpd_ram.sv -----
// ----------------------------------------------------------------------------
// tpd_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/tpd_front.sv -----
// ----------------------------------------------------------------------------
// tpd_front: command intake and classification
// Accepts words, sorts them into insert, query or reject, and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tpd_front
  import tpd_pkg::*;
#(
  parameter int unsigned NODES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                command_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  input  bk_ctl_t             bk_ctl_i,
  output job_t                job_o,
  output fr_st_t              fr_st_o
);

  job_t       q_job_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, out_of_range;
  job_t       job_in;

  assign busy_o = (cnt_q == 2'd2) || bk_ctl_i.clearing;
  assign push   = start_i && !busy_o;

  assign out_of_range = (RANGE_W'(node_a_i) >= RANGE_W'(NODES)) ||
                        (RANGE_W'(node_b_i) >= RANGE_W'(NODES));

  always_comb begin
    job_in.node_a = node_a_i;
    job_in.node_b = node_b_i;
    job_in.weight = edge_weight_i;
    job_in.kind   = KIND_REJECT;
    job_in.status = STATUS_OK;
    if (command_i == CMD_INSERT && node_a_i == node_b_i) begin
      job_in.status = STATUS_SELF;
    end else if (out_of_range) begin
      job_in.status = STATUS_RANGE;
    end else if (command_i == CMD_INSERT) begin
      job_in.kind = KIND_INSERT;
    end else begin
      job_in.kind = KIND_QUERY;
    end
  end

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, bk_ctl_i.pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (bk_ctl_i.pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_job_q[wp_q] <= job_in;
    end
  end

  assign job_o         = q_job_q[rp_q];
  assign fr_st_o.valid = (cnt_q != 2'd0);
  assign fr_st_o.full  = (cnt_q == 2'd2);

endmodule

// ----- hdl/tpd_back.sv -----
// ----------------------------------------------------------------------------
// tpd_back: tree store and walker
// Clears the link memory after reset, performs inserts, and answers
// queries by walking parent links one per cycle.
// ----------------------------------------------------------------------------
module tpd_back
  import tpd_pkg::*;
#(
  parameter int unsigned NODES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  job_t                job_i,
  input  fr_st_t              fr_st_i,
  output bk_ctl_t             bk_ctl_o,
  output logic                result_valid_o,
  output logic [DIST_W-1:0]   distance_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned MW = 1 + AW + WEIGHT_W;
  localparam logic [AW-1:0] LAST = AW'(NODES - 1);

  bk_state_e state_q, state_d;

  logic [AW-1:0]       clr_q, clr_d;
  logic [AW-1:0]       cur_a_q, cur_a_d, cur_b_q, cur_b_d;
  logic [AW-1:0]       org_a_q, org_a_d, org_b_q, org_b_d;
  logic [AW-1:0]       steps_q, steps_d, da_q, da_d;
  logic [AW-1:0]       diff_q, diff_d, lvl_q, lvl_d;
  logic                lift_b_q, lift_b_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic                res_valid_q, res_valid_d;
  logic [DIST_W-1:0]   res_dist_q, res_dist_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [MW-1:0]       wdata, rdata;
  logic                r_valid;
  logic [AW-1:0]       r_par;
  logic [WEIGHT_W-1:0] r_w;

  assign r_valid = rdata[MW-1];
  assign r_par   = rdata[MW-2 -: AW];
  assign r_w     = rdata[WEIGHT_W-1:0];

  tpd_ram #(
    .WIDTH (MW),
    .DEPTH (NODES),
    .AW    (AW)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_a_d      = cur_a_q;
    cur_b_d      = cur_b_q;
    org_a_d      = org_a_q;
    org_b_d      = org_b_q;
    steps_d      = steps_q;
    da_d         = da_q;
    diff_d       = diff_q;
    lvl_d        = lvl_q;
    lift_b_d     = lift_b_q;
    dist_d       = dist_q;
    res_valid_d  = 1'b0;
    res_dist_d   = res_dist_q;
    res_status_d = res_status_q;

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (fr_st_i.valid) begin
          unique case (job_i.kind)
            KIND_QUERY: begin
              org_a_d = AW'(job_i.node_a);
              org_b_d = AW'(job_i.node_b);
              cur_a_d = AW'(job_i.node_a);
              cur_b_d = AW'(job_i.node_b);
              steps_d = '0;
              dist_d  = '0;
              state_d = S_DEP_A;
            end
            KIND_INSERT: begin
              res_valid_d  = 1'b1;
              res_dist_d   = '0;
              res_status_d = STATUS_OK;
            end
            default: begin
              res_valid_d  = 1'b1;
              res_dist_d   = '0;
              res_status_d = job_i.status;
            end
          endcase
        end
      end
      S_DEP_A: begin
        if (!r_valid) begin
          da_d    = steps_q;
          steps_d = '0;
          state_d = S_DEP_B;
        end else if (steps_q == LAST) begin
          res_valid_d  = 1'b1;
          res_dist_d   = '0;
          res_status_d = STATUS_APART;
          state_d      = S_IDLE;
        end else begin
          cur_a_d = r_par;
          steps_d = steps_q + AW'(1);
        end
      end
      S_DEP_B: begin
        if (!r_valid) begin
          cur_a_d = org_a_q;
          cur_b_d = org_b_q;
          if (da_q > steps_q) begin
            lift_b_d = 1'b0;
            diff_d   = da_q - steps_q;
            lvl_d    = steps_q;
            state_d  = S_LIFT;
          end else if (steps_q > da_q) begin
            lift_b_d = 1'b1;
            diff_d   = steps_q - da_q;
            lvl_d    = da_q;
            state_d  = S_LIFT;
          end else begin
            lvl_d = da_q;
            if (org_a_q != org_b_q && da_q != '0) begin
              state_d = S_PAIR_A;
            end else begin
              res_valid_d  = 1'b1;
              res_dist_d   = '0;
              res_status_d = (org_a_q == org_b_q) ? STATUS_OK : STATUS_APART;
              state_d      = S_IDLE;
            end
          end
        end else if (steps_q == LAST) begin
          res_valid_d  = 1'b1;
          res_dist_d   = '0;
          res_status_d = STATUS_APART;
          state_d      = S_IDLE;
        end else begin
          cur_b_d = r_par;
          steps_d = steps_q + AW'(1);
        end
      end
      S_LIFT: begin
        dist_d = add_sat(dist_q, r_w);
        if (lift_b_q) cur_b_d = r_par;
        else          cur_a_d = r_par;
        diff_d = diff_q - AW'(1);
        if (diff_q == AW'(1)) begin
          if (cur_a_d != cur_b_d && lvl_q != '0) begin
            state_d = S_PAIR_A;
          end else begin
            res_valid_d  = 1'b1;
            res_dist_d   = (cur_a_d == cur_b_d) ? dist_d : '0;
            res_status_d = (cur_a_d == cur_b_d) ? STATUS_OK : STATUS_APART;
            state_d      = S_IDLE;
          end
        end
      end
      S_PAIR_A: begin
        dist_d  = add_sat(dist_q, r_w);
        cur_a_d = r_par;
        state_d = S_PAIR_B;
      end
      S_PAIR_B: begin
        dist_d  = add_sat(dist_q, r_w);
        cur_b_d = r_par;
        lvl_d   = lvl_q - AW'(1);
        if (cur_a_q != r_par && lvl_q != AW'(1)) begin
          state_d = S_PAIR_A;
        end else begin
          res_valid_d  = 1'b1;
          res_dist_d   = (cur_a_q == r_par) ? dist_d : '0;
          res_status_d = (cur_a_q == r_par) ? STATUS_OK : STATUS_APART;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: queue pop, memory ports
  always_comb begin
    bk_ctl_o.pop      = (state_q == S_IDLE) && fr_st_i.valid;
    bk_ctl_o.clearing = (state_q == S_CLEAR);
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (state_q == S_CLEAR) begin
      we = 1'b1;
    end else if (bk_ctl_o.pop && job_i.kind == KIND_INSERT) begin
      we    = 1'b1;
      waddr = AW'(job_i.node_a);
      wdata = {1'b1, AW'(job_i.node_b), job_i.weight};
    end
    unique case (state_d)
      S_DEP_B, S_PAIR_B: raddr = cur_b_d;
      S_LIFT:            raddr = lift_b_d ? cur_b_d : cur_a_d;
      default:           raddr = cur_a_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_a_q      <= cur_a_d;
    cur_b_q      <= cur_b_d;
    org_a_q      <= org_a_d;
    org_b_q      <= org_b_d;
    steps_q      <= steps_d;
    da_q         <= da_d;
    diff_q       <= diff_d;
    lvl_q        <= lvl_d;
    lift_b_q     <= lift_b_d;
    dist_q       <= dist_d;
    res_dist_q   <= res_dist_d;
    res_status_q <= res_status_d;
  end

  assign result_valid_o = res_valid_q;
  assign distance_o     = res_dist_q;
  assign status_o       = res_status_q;

endmodule
